FILE: sv/block_reverse_k_group_top_defines.svh
// assertion macros shared by the block's checker
`ifndef BLOCK_REVERSE_K_GROUP_TOP_DEFINES_SVH
`define BLOCK_REVERSE_K_GROUP_TOP_DEFINES_SVH

// property that must hold at every edge out of reset
`define BRG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// implication into the following cycle
`define BRG_ASSERT_NEXT(lbl, ante, cons, msg) \
  `BRG_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: sv/brg_pkg.sv
// shared types and constants of the group reversal block
package brg_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CFG_W   = 5;

  // group size after reset
  localparam logic [CFG_W-1:0] GROUP_SIZE_RST = 5'd2;

  // sequencer states
  typedef enum logic [0:0] {
    ST_COLLECT,
    ST_DRAIN
  } brg_state_e;

  // buffer port strobes
  typedef struct packed {
    logic we;
    logic re;
  } brg_mem_ctl_t;

endpackage

FILE: sv/brg_mem.sv
// group buffer: one write port, one read port with registered read data
module brg_mem
  import brg_pkg::*;
#(
  parameter int unsigned Depth = 16,
  parameter int unsigned AW    = $clog2(Depth)
) (
  input  logic               clk_i,
  input  brg_mem_ctl_t       ctl_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [VALUE_W-1:0] wdata_i,
  input  logic [AW-1:0]      raddr_i,
  output logic [VALUE_W-1:0] rdata_o
);

  logic [VALUE_W-1:0] mem_q [Depth];
  logic [VALUE_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held while no read is issued
  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/brg_ctrl.sv
// fill and drain sequencer of the group buffer
module brg_ctrl
  import brg_pkg::*;
#(
  parameter int unsigned MaxGroup = 16,
  parameter int unsigned AW       = $clog2(MaxGroup),
  parameter int unsigned CW       = $clog2(MaxGroup + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CFG_W-1:0]   cfg_data_i,
  // input requests
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [VALUE_W-1:0] in_value_i,
  input  logic               in_last_i,
  // output requests
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_last_o,
  // buffer access
  output brg_mem_ctl_t       mem_ctl_o,
  output logic [AW-1:0]      waddr_o,
  output logic [VALUE_W-1:0] wdata_o,
  output logic [AW-1:0]      raddr_o
);

  brg_state_e       state_q, state_d;
  logic [CFG_W-1:0] gsize_q;
  logic [CW-1:0]    fill_q, fill_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic             rev_q, rev_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;
  logic             out_last_q, out_last_d;

  logic [CW-1:0]    k_eff;
  logic             in_acc;
  logic             issue;
  logic             store;
  logic [CW-1:0]    n_new;
  logic [CW-1:0]    n_m1;
  logic             close_grp;
  logic             flush;

  // group size register: the user must write it only while idle; the block does not enforce this
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gsize_q <= GROUP_SIZE_RST;
    end else if (cfg_valid_i) begin
      gsize_q <= cfg_data_i;
    end
  end

  // effective group size, clamped to one up to the buffer depth
  always_comb begin
    if (gsize_q == '0) begin
      k_eff = CW'(1);
    end else if (32'(gsize_q) > 32'(MaxGroup)) begin
      k_eff = CW'(MaxGroup);
    end else begin
      k_eff = CW'(gsize_q);
    end
  end

  // fill count after this value and group decisions
  assign store     = 32'(fill_q) < 32'(MaxGroup);
  assign n_new     = store ? fill_q + CW'(1) : fill_q;
  assign n_m1      = n_new - CW'(1);
  assign close_grp = n_new >= k_eff;
  assign flush     = close_grp || in_last_i;

  // sequencer outputs
  always_comb begin
    in_ready_o = (state_q == ST_COLLECT);
    issue      = (state_q == ST_DRAIN) && (!out_valid_q || out_ready_i);
  end

  assign in_acc = in_valid_i && in_ready_o;

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_COLLECT: begin
        if (in_acc && flush) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (issue && cnt_q == CW'(1)) begin
          state_d = ST_COLLECT;
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  // drain bookkeeping
  always_comb begin
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    rev_d       = rev_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    if (in_acc) begin
      fill_d = flush ? '0 : n_new;
      if (flush) begin
        cnt_d  = n_new;
        ptr_d  = close_grp ? n_m1[AW-1:0] : '0;
        rev_d  = close_grp;
        last_d = in_last_i;
      end
    end
    if (issue) begin
      cnt_d       = cnt_q - CW'(1);
      ptr_d       = rev_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
      out_valid_d = 1'b1;
      out_last_d  = last_q && (cnt_q == CW'(1));
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      fill_q      <= '0;
      cnt_q       <= '0;
      ptr_q       <= '0;
      rev_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      rev_q       <= rev_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  // buffer access
  assign mem_ctl_o.we = in_acc && store;
  assign mem_ctl_o.re = issue;
  assign waddr_o      = fill_q[AW-1:0];
  assign wdata_o      = in_value_i;
  assign raddr_o      = ptr_q;

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: sv/block_reverse_k_group_top.sv
// top level of the group reversal block
//
//  channel   | direction | payload
//  ----------+-----------+---------------------------------------------
//  s_axis    | in        | tdata: value[31:0]; tlast: last_in
//  m_axis    | out       | tdata: out_value[31:0]; tlast: last_out
//  cfg       | in        | data: group_size[4:0]
//
// values are written into the buffer one per cycle while a group fills.
// when a group closes (k values, or the last flag), input is held off while
// the single read port drains the group one entry per cycle unless m_axis stalls.
// the read data register is the output stage and holds under m_axis stalls.
// reset clears the fill count and sets the group size to 2; buffer contents
// are not cleared, every entry is written before it is read.
module block_reverse_k_group_top
  import brg_pkg::*;
#(
  parameter int unsigned MAX_GROUP = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CFG_W-1:0]   cfg_data_i,     // group_size
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [VALUE_W-1:0] s_axis_tdata,   // value
  input  logic               s_axis_tlast,
  // output stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [VALUE_W-1:0] m_axis_tdata,   // out_value
  output logic               m_axis_tlast
);

  localparam int unsigned AW = $clog2(MAX_GROUP);

  brg_mem_ctl_t       mem_ctl;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [VALUE_W-1:0] wdata;

  // sequencer
  brg_ctrl #(
    .MaxGroup (MAX_GROUP)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_value_i  (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_last_o  (m_axis_tlast),
    .mem_ctl_o   (mem_ctl),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr)
  );

  // group buffer
  brg_mem #(
    .Depth (MAX_GROUP)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (m_axis_tdata)
  );

endmodule

FILE: sv/brg_checker.sv
// port-level checks of the group reversal block and their binding
`include "block_reverse_k_group_top_defines.svh"

module brg_checker
  import brg_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [CFG_W-1:0]   cfg_data_i,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic [VALUE_W-1:0] s_axis_tdata,
  input logic               s_axis_tlast,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [VALUE_W-1:0] m_axis_tdata,
  input logic               m_axis_tlast
);

  // a stalled result keeps its payload
  `BRG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // a last flag always closes the group and starts a drain
  `BRG_ASSERT_NEXT(a_last_drains, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "no drain after last request")

  // input is held off only after a request closed a group
  `BRG_ASSERT(a_ready_fall, $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready), "ready dropped without a request")

endmodule

bind block_reverse_k_group_top brg_checker u_brg_checker (.*);

FILE: tb/sv/block_reverse_k_group_top_tb.sv
// self-checking testbench for the group reversal block: directed table, then random sequences
module block_reverse_k_group_top_tb
  import brg_pkg::*;
;

  localparam int unsigned MAX_GRP        = 16;
  // cycles allowed for a group still draining when nothing is expected
  localparam int unsigned SETTLE_CYCLES  = MAX_GRP + 4;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_ITEMS   = 200;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } reordered_t;

  typedef enum logic [0:0] {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [VALUE_W-1:0] data;
    logic               last;
    logic               typed;
    reordered_t         typed_res;
  } dir_row_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_PERIODIC,
    RX_BURSTY
  } rx_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [CFG_W-1:0]   cfg_data_i    = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [VALUE_W-1:0] s_axis_tdata  = '0;   // value
  logic               s_axis_tlast  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [VALUE_W-1:0] m_axis_tdata;         // out_value
  logic               m_axis_tlast;

  // own copy of the block state and its register
  logic [VALUE_W-1:0] held_values [MAX_GRP];
  int unsigned        held_count     = 0;
  logic [CFG_W-1:0]   group_size_cfg = GROUP_SIZE_RST;

  reordered_t  reordered_q [$];
  dir_row_t    dir_rows [$];
  int unsigned error_count    = 0;
  int unsigned items_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned cfg_writes     = 0;
  int unsigned burst_left     = 0;
  int unsigned idle_cycles    = 0;
  int unsigned rx_cycle       = 0;
  int unsigned rx_hold        = 0;
  rx_mode_e    rx_mode        = RX_OPEN;

  block_reverse_k_group_top #(
    .MAX_GROUP(MAX_GRP)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // group reversal predictor: store the value, close a full group reversed
  // or a partial group in order on the last flag
  function automatic void reorder_value(input logic [VALUE_W-1:0] v, input logic l);
    int unsigned k;
    int unsigned n;
    reordered_t  r;
    k = group_size_cfg;
    if (k < 1) k = 1;
    if (k > MAX_GRP) k = MAX_GRP;
    if (held_count < MAX_GRP) begin
      held_values[held_count] = v;
      held_count++;
    end
    n = held_count;
    if (n >= k || l) begin
      for (int unsigned i = 0; i < n; i++) begin
        r.value = (n >= k) ? held_values[n - 1 - i] : held_values[i];
        r.last  = l && (i == n - 1);
        reordered_q.push_back(r);
      end
      held_count = 0;
    end
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(input row_kind_e kind, input logic [VALUE_W-1:0] data,
                         input logic last, input logic typed,
                         input logic [VALUE_W-1:0] tv, input logic tl);
    dir_row_t row;
    row.kind            = kind;
    row.data            = data;
    row.last            = last;
    row.typed           = typed;
    row.typed_res.value = tv;
    row.typed_res.last  = tl;
    dir_rows.push_back(row);
  endtask

  // one input request, with bursts and random gaps on the sender side
  task automatic send_value(input logic [VALUE_W-1:0] v, input logic l,
                            input logic typed, input reordered_t typed_res);
    int unsigned gap;
    int unsigned prior;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 8);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= l;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    prior = reordered_q.size();
    reorder_value(v, l);
    // rows with a result written out by hand replace the predicted one
    if (typed) begin
      while (reordered_q.size() > prior) void'(reordered_q.pop_back());
      reordered_q.push_back(typed_res);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  // drop the input request, wait for all results and any drain still running
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (reordered_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_group_size(input logic [CFG_W-1:0] k);
    settle_block();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= k;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    group_size_cfg = k;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver stalls, pattern picked at random from open, random, periodic and bursty
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 50 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:     m_axis_tready <= 1'b1;
      RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 2) != 0);
      RX_PERIODIC: m_axis_tready <= (rx_cycle % 4 != 3);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 10);
        end
      end
    endcase
  end

  // result checking and watchdog
  always @(posedge clk_i) begin
    reordered_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (reordered_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result value %h last %b", $time, m_axis_tdata,
                   m_axis_tlast);
        end else begin
          want = reordered_q.pop_front();
          if (m_axis_tdata !== want.value) begin
            error_count++;
            $display("%0t: out_value expected %h actual %h", $time, want.value,
                     m_axis_tdata);
          end
          if (m_axis_tlast !== want.last) begin
            error_count++;
            $display("%0t: last_out expected %b actual %b", $time, want.last,
                     m_axis_tlast);
          end
        end
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request accepted for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, reordered_q.size());
        $display("block_reverse_k_group_top_tb: errors");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned random_items;
    int unsigned phase;
    int unsigned k_eff;
    int unsigned seq_len;
    int unsigned n_seq;
    logic [CFG_W-1:0] k_pick;
    logic             l;
    reordered_t       none;
    // reset edge lands after every process is waiting on it
    rst_ni <= 1'b0;
    none = '0;
    random_items = 0;

    // directed rows, group size 2 out of reset
    add_row(ROW_ITEM, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b1);
    add_row(ROW_ITEM, 32'h7fff_ffff, 1'b0, 1'b0, '0, 1'b0);
    add_row(ROW_ITEM, 32'h0000_0001, 1'b0, 1'b0, '0, 1'b0);
    add_row(ROW_ITEM, 32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff, 1'b1);
    // group size one passes values straight through
    add_row(ROW_CFG,  32'd1, 1'b0, 1'b0, '0, 1'b0);
    add_row(ROW_ITEM, 32'h1234_5678, 1'b0, 1'b1, 32'h1234_5678, 1'b0);
    add_row(ROW_ITEM, 32'hedcb_a987, 1'b1, 1'b1, 32'hedcb_a987, 1'b1);
    // group size zero is taken as one
    add_row(ROW_CFG,  32'd0, 1'b0, 1'b0, '0, 1'b0);
    add_row(ROW_ITEM, 32'ha5a5_a5a5, 1'b0, 1'b1, 32'ha5a5_a5a5, 1'b0);
    add_row(ROW_ITEM, 32'h5a5a_5a5a, 1'b1, 1'b1, 32'h5a5a_5a5a, 1'b1);
    // last flag on a full group, then a partial group
    add_row(ROW_CFG,  32'd3, 1'b0, 1'b0, '0, 1'b0);
    add_row(ROW_ITEM, 32'h10, 1'b0, 1'b0, '0, 1'b0);
    add_row(ROW_ITEM, 32'h20, 1'b0, 1'b0, '0, 1'b0);
    add_row(ROW_ITEM, 32'h30, 1'b1, 1'b0, '0, 1'b0);
    add_row(ROW_ITEM, 32'h40, 1'b0, 1'b0, '0, 1'b0);
    add_row(ROW_ITEM, 32'h50, 1'b1, 1'b0, '0, 1'b0);
    // group size lowered while two values are held
    add_row(ROW_ITEM, 32'h60, 1'b0, 1'b0, '0, 1'b0);
    add_row(ROW_ITEM, 32'h70, 1'b0, 1'b0, '0, 1'b0);
    add_row(ROW_CFG,  32'd2, 1'b0, 1'b0, '0, 1'b0);
    add_row(ROW_ITEM, 32'h80, 1'b0, 1'b0, '0, 1'b0);
    // size above the buffer depth saturates
    add_row(ROW_CFG,  32'd31, 1'b0, 1'b0, '0, 1'b0);
    add_row(ROW_ITEM, 32'h90, 1'b0, 1'b0, '0, 1'b0);
    add_row(ROW_ITEM, 32'ha0, 1'b0, 1'b0, '0, 1'b0);
    add_row(ROW_ITEM, 32'hb0, 1'b1, 1'b0, '0, 1'b0);
    add_row(ROW_CFG,  32'd16, 1'b0, 1'b0, '0, 1'b0);
    add_row(ROW_ITEM, 32'hc0, 1'b1, 1'b1, 32'hc0, 1'b1);

    // reset
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_group_size(dir_rows[i].data[CFG_W-1:0]);
      end else begin
        send_value(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
                   dir_rows[i].typed_res);
      end
    end

    // random phases: extremes of the size first, then mostly small groups
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase)
        0:       k_pick = 5'd1;
        1:       k_pick = 5'd16;
        2:       k_pick = 5'd31;
        3:       k_pick = 5'd0;
        4:       k_pick = 5'd17;
        default: begin
          if ($urandom_range(0, 3) != 0) k_pick = $urandom_range(1, 6);
          else k_pick = $urandom_range(0, 31);
        end
      endcase
      write_group_size(k_pick);
      k_eff = (k_pick < 1) ? 1 : ((k_pick > MAX_GRP) ? MAX_GRP : k_pick);
      n_seq = $urandom_range(1, 4);
      for (int unsigned s = 0; s < n_seq; s++) begin
        seq_len = $urandom_range(1, 3 * k_eff + 1);
        for (int unsigned j = 0; j < seq_len; j++) begin
          // a few sequences lose their last flag and run into the next one
          l = (j == seq_len - 1) && ($urandom_range(0, 5) != 0);
          send_value(rand_value(), l, 1'b0, none);
          random_items++;
        end
      end
      phase++;
    end
    // flush whatever is still held
    send_value(rand_value(), 1'b1, 1'b0, none);

    settle_block();
    $display("covered %0d input values, %0d results checked, %0d group size writes",
             items_sent, results_seen, cfg_writes);
    $display("group sizes included zero, one, sixteen and values above the buffer depth");
    if (error_count == 0) begin
      $display("block_reverse_k_group_top_tb: clean");
    end else begin
      $display("block_reverse_k_group_top_tb: errors");
    end
    $finish;
  end

endmodule
